// File: src/assert_macros.svh
// assertion macros included by the queue rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// checked property, skipped while reset is high
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// checked property, also evaluated during reset
`define ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst, prop, msg)
`define ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

// File: src/bppq_pkg.sv
// types and constants of the bounded priority packet queue
package bppq_pkg;

  typedef struct packed {
    logic [15:0] arrival;
    logic [15:0] size;
    logic [3:0]  prio;
    logic [15:0] id;
  } entry_t;

  typedef struct packed {
    logic   enq;
    logic   deq;
    entry_t din;
  } cell_cmd_t;

  typedef enum logic [1:0] {
    ST_ENQUEUED = 2'd0,
    ST_DROPPED  = 2'd1,
    ST_DEQUEUED = 2'd2,
    ST_EMPTY    = 2'd3
  } status_t;

  localparam logic ACT_ENQ = 1'b0;
  localparam logic ACT_DEQ = 1'b1;

  localparam logic REG_MAX_OCC = 1'b0;
  localparam logic [6:0] MAX_OCC_RESET = 7'd50;
  localparam logic [15:0] DROP_MAX = 16'hFFFF;

endpackage

// File: src/bppq_cell.sv
// one slot of the sorted chain: keeps, takes the new packet or shifts
module bppq_cell (
  input  logic                 clk,
  input  bppq_pkg::cell_cmd_t  cmd,
  input  logic                 occ,
  input  logic                 left_le,
  input  bppq_pkg::entry_t     left_entry,
  input  bppq_pkg::entry_t     right_entry,
  output logic                 le,
  output bppq_pkg::entry_t     entry
);
  import bppq_pkg::*;

  // this slot stays ahead of the new packet
  assign le = occ && (entry.prio <= cmd.din.prio);

  always_ff @(posedge clk) begin
    if (cmd.enq) begin
      if (!le) begin
        // first slot behind the last lower-or-equal one takes the packet
        if (left_le) begin
          entry <= cmd.din;
        end else begin
          entry <= left_entry;
        end
      end
    end else if (cmd.deq) begin
      entry <= right_entry;
    end
  end

endmodule

// File: src/bounded_priority_packet_queue.sv
// bounded priority packet queue: s channel takes enqueue/dequeue requests, m returns one
// result for each. tuser on s is the action (0 enqueue, 1 dequeue); tdata carries id,
// priority, size (8.8) and timestamp. tuser on m is the status; tdata carries the head
// packet fields, wait time, occupancy and the saturating drop count.
// storage is a chain of DEPTH cells; every enqueue compares against all cells in parallel
// and shifts the tail one slot back, a dequeue shifts the whole chain one slot forward.
// the result appears in the output register in the cycle after the transfer.
// throughput: one request per cycle unless m stalls, set by the compare-and-shift chain.
// the output register holds the result while m_tready is low; s_tready drops then and
// no request is taken until the result leaves.
// reset clears the fill and drop counters and sets the capacity to 50; no clearing pass.
// the user must write capacity over apb at address 0 while the queue is idle; unchecked.
module bounded_priority_packet_queue #(
  parameter int DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,   // packet_id, priority_req, packet_size, timestamp, pad
  input  logic        s_tuser,   // action
  output logic        m_tvalid,
  input  logic        m_tready,
  // out_id, out_priority, out_size, out_arrival, wait_time, occupancy, drop_total, pad
  output logic [95:0] m_tdata,
  output logic [1:0]  m_tuser,   // status
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import bppq_pkg::*;

  localparam int FW = $clog2(DEPTH + 1);
  localparam int LW = (FW > 7) ? FW : 7;

  logic [6:0]    max_occ;
  logic [FW-1:0] fill, fill_next;
  logic [15:0]   drop, drop_next;

  entry_t        cell_q [DEPTH];
  logic          cell_le [DEPTH];
  cell_cmd_t     cmd;

  logic          accept, act;
  logic [LW-1:0] lim_w, fill_w;
  logic          can_enq, nonempty;
  status_t       st_next;
  entry_t        head;
  logic [15:0]   wait_next;

  // configuration port
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      max_occ <= MAX_OCC_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_MAX_OCC)) begin
      max_occ <= pwdata[6:0];
    end
  end
  assign prdata = (paddr[2] == REG_MAX_OCC) ? {25'd0, max_occ} : 32'd0;

  // request decode
  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign act      = s_tuser;
  assign lim_w    = (LW'(max_occ) > LW'(DEPTH)) ? LW'(DEPTH) : LW'(max_occ);
  assign fill_w   = LW'(fill);
  assign can_enq  = fill_w < lim_w;
  assign nonempty = fill != '0;

  assign cmd.enq         = accept && (act == ACT_ENQ) && can_enq;
  assign cmd.deq         = accept && (act == ACT_DEQ) && nonempty;
  assign cmd.din.id      = s_tdata[15:0];
  assign cmd.din.prio    = s_tdata[19:16];
  assign cmd.din.size    = s_tdata[35:20];
  assign cmd.din.arrival = s_tdata[51:36];

  // cell chain
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam logic [FW-1:0] IDX = FW'(i);
    entry_t left_e, right_e;
    logic   left_le;
    if (i == 0) begin : g_first
      assign left_e  = cmd.din;
      assign left_le = 1'b1;
    end else begin : g_mid
      assign left_e  = cell_q[i-1];
      assign left_le = cell_le[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_e = cell_q[i];
    end else begin : g_inner
      assign right_e = cell_q[i+1];
    end
    bppq_cell u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .occ         (IDX < fill),
      .left_le     (left_le),
      .left_entry  (left_e),
      .right_entry (right_e),
      .le          (cell_le[i]),
      .entry       (cell_q[i])
    );
  end

  // counters and status
  assign head      = cell_q[0];
  assign wait_next = s_tdata[51:36] - head.arrival;

  always_comb begin
    fill_next = fill;
    drop_next = drop;
    st_next   = ST_ENQUEUED;
    unique case (act)
      ACT_ENQ: begin
        if (can_enq) begin
          fill_next = fill + FW'(1);
          st_next   = ST_ENQUEUED;
        end else begin
          if (drop != DROP_MAX) begin
            drop_next = drop + 16'd1;
          end
          st_next = ST_DROPPED;
        end
      end
      ACT_DEQ: begin
        if (nonempty) begin
          fill_next = fill - FW'(1);
          st_next   = ST_DEQUEUED;
        end else begin
          st_next = ST_EMPTY;
        end
      end
      default: st_next = ST_EMPTY;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill     <= '0;
      drop     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        fill     <= fill_next;
        drop     <= drop_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  logic [LW-1:0] occ_w;
  assign occ_w = LW'(fill_next);

  // result register, payload only
  always_ff @(posedge clk) begin
    if (accept) begin
      m_tuser        <= st_next;
      m_tdata[95:91] <= 5'd0;
      m_tdata[90:75] <= drop_next;
      m_tdata[74:68] <= occ_w[6:0];
      if (st_next == ST_DEQUEUED) begin
        m_tdata[15:0]  <= head.id;
        m_tdata[19:16] <= head.prio;
        m_tdata[35:20] <= head.size;
        m_tdata[51:36] <= head.arrival;
        m_tdata[67:52] <= wait_next;
      end else begin
        m_tdata[67:0]  <= '0;
      end
    end
  end

  // checks
  `include "assert_macros.svh"

  `ASSERT_NR(a_reset_clear, clk, rst |=> (fill == '0) && (drop == '0),
             "counters not cleared by reset")
  `ASSERT_CLK(a_fill_bound, clk, rst, LW'(fill) <= LW'(DEPTH),
              "fill above depth")
  `ASSERT_CLK(a_deq_dec, clk, rst, cmd.deq |=> fill == $past(fill) - FW'(1),
              "dequeue did not lower fill")
  `ASSERT_CLK(a_drop_inc, clk, rst,
              accept && (act == ACT_ENQ) && !can_enq && (drop != DROP_MAX) |=>
              drop == $past(drop) + 16'd1,
              "drop not counted")
  `ASSERT_CLK(a_sorted_head, clk, rst, (LW'(fill) >= LW'(2)) |->
              cell_q[0].prio <= cell_q[1].prio,
              "head out of priority order")

endmodule

// File: sim/bounded_priority_packet_queue_tb.sv
`timescale 1ns / 100ps
// testbench of the bounded priority packet queue: directed and random traffic against a scoreboard
module bounded_priority_packet_queue_tb;
  import bppq_pkg::*;

  localparam int DEPTH = 64;
  localparam int STALL_LIMIT = 5000;
  localparam int LONG_HOLD = 400;

  typedef struct packed {
    logic        action;
    logic [15:0] id;
    logic [3:0]  prio;
    logic [15:0] size;
    logic [15:0] ts;
  } request_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] id;
    logic [3:0]  prio;
    logic [15:0] size;
    logic [15:0] arrival;
    logic [15:0] wait_time;
    logic [6:0]  occupancy;
    logic [15:0] drops;
  } outcome_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [55:0] s_tdata = '0;   // packet_id, priority_req, packet_size, timestamp, pad
  logic        s_tuser = 1'b0; // action
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  // out_id, out_priority, out_size, out_arrival, wait_time, occupancy, drop_total, pad
  logic [95:0] m_tdata;
  logic [1:0]  m_tuser;        // status
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // stimulus and scoreboard state
  request_t requests[$];
  request_t next_req;
  outcome_t due_results[$];
  outcome_t got;
  int       send_idle = 0;
  int       recv_idle = 0;
  int       errors = 0;
  int       quiet = 0;
  int       hold_left = 0;
  logic     hold_kick = 1'b0;
  logic [15:0] stamp = '0;

  // predictor state
  entry_t      held[$];
  logic [6:0]  capacity = MAX_OCC_RESET;
  logic [15:0] drops = '0;

  bounded_priority_packet_queue #(.DEPTH(DEPTH)) i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // sorted insertion: a new packet goes behind every entry with priority <= its own
  function automatic outcome_t schedule_request(logic action, logic [55:0] data);
    entry_t   pkt;
    outcome_t res;
    int       lim;
    int       pos;
    pkt.id = data[15:0];
    pkt.prio = data[19:16];
    pkt.size = data[35:20];
    pkt.arrival = data[51:36];
    res = '0;
    lim = (capacity > DEPTH) ? DEPTH : int'(capacity);
    if (action == ACT_ENQ) begin
      if (held.size() < lim) begin
        pos = 0;
        while (pos < held.size() && held[pos].prio <= pkt.prio) pos++;
        held.insert(pos, pkt);
        res.status = ST_ENQUEUED;
      end else begin
        if (drops != DROP_MAX) drops++;
        res.status = ST_DROPPED;
      end
    end else if (held.size() == 0) begin
      res.status = ST_EMPTY;
    end else begin
      pkt = held.pop_front();
      res.status = ST_DEQUEUED;
      res.id = pkt.id;
      res.prio = pkt.prio;
      res.size = pkt.size;
      res.arrival = pkt.arrival;
      res.wait_time = data[51:36] - pkt.arrival;
    end
    res.occupancy = 7'(held.size());
    res.drops = drops;
    return res;
  endfunction

  task automatic flag_error(string msg);
    $display("%0t: %s", $realtime, msg);
    errors++;
  endtask

  task automatic check_field(string name, logic [15:0] g, logic [15:0] w);
    if (g !== w) flag_error($sformatf("%s is %0h, expected %0h", name, g, w));
  endtask

  // driver: holds tvalid until the transfer, then takes the next pending request
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (requests.size() > 0 && $urandom_range(99) >= send_idle) begin
        next_req = requests.pop_front();
        s_tvalid <= 1'b1;
        s_tuser <= next_req.action;
        s_tdata <= {4'b0, next_req.ts, next_req.size, next_req.prio, next_req.id};
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // monitor: predicts on each input transfer, checks each output transfer
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) due_results.push_back(schedule_request(s_tuser, s_tdata));
      if (m_tvalid && m_tready) begin
        got.status = status_t'(m_tuser);
        got.id = m_tdata[15:0];
        got.prio = m_tdata[19:16];
        got.size = m_tdata[35:20];
        got.arrival = m_tdata[51:36];
        got.wait_time = m_tdata[67:52];
        got.occupancy = m_tdata[74:68];
        got.drops = m_tdata[90:75];
        if (due_results.size() == 0) begin
          flag_error("result transfer with nothing outstanding");
        end else begin
          outcome_t want;
          want = due_results.pop_front();
          check_field("status", 16'(got.status), 16'(want.status));
          check_field("out_id", got.id, want.id);
          check_field("out_priority", 16'(got.prio), 16'(want.prio));
          check_field("out_size", got.size, want.size);
          check_field("out_arrival", got.arrival, want.arrival);
          check_field("wait_time", got.wait_time, want.wait_time);
          check_field("occupancy", 16'(got.occupancy), 16'(want.occupancy));
          check_field("drop_total", got.drops, want.drops);
        end
      end
      m_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle);
    end
  end

  // long receiver hold-off, counted here
  always @(posedge clk) begin
    if (rst) hold_left <= 0;
    else if (hold_kick) hold_left <= LONG_HOLD;
    else if (hold_left > 0) hold_left <= hold_left - 1;
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet == STALL_LIMIT) begin
      $display("bounded_priority_packet_queue_tb: errors");
      $finish;
    end
  end

  task automatic push_enq(logic [15:0] id, logic [3:0] prio, logic [15:0] size,
                          logic [15:0] ts);
    requests.push_back('{action: ACT_ENQ, id: id, prio: prio, size: size, ts: ts});
  endtask

  task automatic push_deq(logic [15:0] ts);
    requests.push_back('{action: ACT_DEQ, id: '0, prio: '0, size: '0, ts: ts});
  endtask

  // checked between edges so the driver's latest pick is already visible
  task automatic drain();
    while (requests.size() > 0 || s_tvalid || m_tvalid || due_results.size() > 0)
      @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capacity(logic [6:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {REG_MAX_OCC, 2'b00};
    pwdata <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    capacity = value;
  endtask

  // bursts of enqueues and dequeues around the capacity, with some noise
  task automatic random_traffic(int count);
    int lim;
    int run;
    int lo;
    int hi;
    lim = (capacity > DEPTH) ? DEPTH : int'(capacity);
    while (count > 0) begin
      case ($urandom_range(9))
        0: begin
          requests.push_back('{action: 1'($urandom_range(1)), id: 16'($urandom),
                               prio: 4'($urandom), size: 16'($urandom), ts: 16'($urandom)});
          run = 1;
        end
        1, 2, 3, 4, 5: begin
          run = $urandom_range(1, lim + 4);
          // narrow priority band forces many ties
          if ($urandom_range(1)) begin
            lo = $urandom_range(14);
            hi = lo + 1;
          end else begin
            lo = 0;
            hi = 15;
          end
          repeat (run) begin
            stamp += 16'($urandom_range(40));
            push_enq(16'($urandom), 4'($urandom_range(hi, lo)), 16'($urandom), stamp);
          end
        end
        default: begin
          run = $urandom_range(1, lim + 4);
          repeat (run) begin
            stamp += 16'($urandom_range(40));
            push_deq(stamp);
          end
        end
      endcase
      count -= run;
    end
  endtask

  initial begin
    int caps[6];
    caps = '{127, 3, 64, 17, 50, 8};
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    send_idle = 8;
    recv_idle = 82;

    // reset capacity: empty dequeue, field extremes, priority ties, wrapped wait time
    push_deq(16'h0000);
    push_enq(16'hFFFF, 4'd15, 16'hFFFF, 16'hFFFF);
    push_enq(16'h0000, 4'd0, 16'h0000, 16'h0000);
    push_enq(16'h0001, 4'd15, 16'h0180, 16'h0005);
    push_enq(16'h0002, 4'd7, 16'h1234, 16'h0006);
    push_enq(16'h0003, 4'd0, 16'h8001, 16'h0007);
    push_deq(16'h0010);
    push_deq(16'h0010);
    push_deq(16'h0010);
    push_deq(16'h0004);
    push_deq(16'hFFFF);
    push_deq(16'h0020);
    drain();

    write_capacity(7'd1);
    push_enq(16'h00A5, 4'd3, 16'h0100, 16'h0030);
    push_enq(16'h005A, 4'd1, 16'h0200, 16'h0031);
    push_deq(16'h0040);
    push_deq(16'h0041);
    drain();

    // zero capacity drops every enqueue
    write_capacity(7'd0);
    push_enq(16'h1111, 4'd0, 16'h0001, 16'h0050);
    push_deq(16'h0051);
    drain();

    stamp = 16'h0060;
    for (int p = 0; p < 6; p++) begin
      if (p == 2) begin
        send_idle = 82;
        recv_idle = 8;
      end else if (p == 4) begin
        send_idle = 0;
        recv_idle = 0;
      end
      write_capacity(p == 3 ? 7'($urandom_range(1, 64)) : 7'(caps[p]));
      random_traffic(280);
      if (p == 5) begin
        // receiver stalls while the sender keeps offering
        hold_kick <= 1'b1;
        @(posedge clk);
        hold_kick <= 1'b0;
      end
      drain();
    end

    if (errors == 0) begin
      $display("bounded_priority_packet_queue_tb: clean");
    end else begin
      $display("bounded_priority_packet_queue_tb: errors");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+src
src/bppq_pkg.sv
src/bppq_cell.sv
src/bounded_priority_packet_queue.sv
sim/bounded_priority_packet_queue_tb.sv
